[rtl/cvls_pkg.sv]
// ----------------------------------------------------------------------------
// cvls_pkg: shared types and constants for the cell voltage list statistics
// Holds the controller states, the command/status bundles between the
// controller and the datapath, the default sizing and the parser constants.
// ----------------------------------------------------------------------------
package cvls_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int MAX_FIELDS_DEF = 24;
  localparam int MAX_CELLS_DEF  = 20;

  // Field numbering and limits
  localparam int FIRST_CELL = 3;
  localparam int MIN_FIELDS = 6;

  localparam logic [16:0] MIN_RESET = 17'd99999;
  localparam logic [19:0] VALUE_SAT = 20'd65535;

  // Characters the parser reacts to
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_NINE       = 8'h39;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_START,
    ST_DIV,
    ST_LOAD
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic acc_en;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

[rtl/cvls_ctrl.sv]
// ----------------------------------------------------------------------------
// cvls_ctrl: message sequencer
// Accepts bytes until the last one, then runs the mean division and hands
// the finished report to the output register.
// ----------------------------------------------------------------------------
module cvls_ctrl import cvls_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_last_byte,
  output logic   in_stall,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_RUN: begin
        in_stall   = 1'b0;
        cmd.acc_en = in_valid;
        if (in_valid && in_last_byte) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_LOAD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

endmodule

[rtl/cvls_dp.sv]
// ----------------------------------------------------------------------------
// cvls_dp: parser, running statistics, mean divider and output register
// Builds decimal fields from digit bytes, folds cell fields into min, max
// and sum, divides the sum by the cell count one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cvls_dp import cvls_pkg::*; #(
  parameter int MAX_FIELDS = MAX_FIELDS_DEF,
  parameter int MAX_CELLS  = MAX_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_report_valid,
  output logic [4:0]  out_cell_count,
  output logic [15:0] out_min_mv,
  output logic [15:0] out_max_mv,
  output logic [15:0] out_mean_mv,
  output logic [15:0] out_spread_mv
);

  localparam int IDX_W    = $clog2(MAX_FIELDS + 1);
  localparam int CNT_W    = $clog2(MAX_CELLS + 1);
  localparam int SUM_W    = 16 + $clog2(MAX_CELLS);
  localparam int STEP_W   = $clog2(SUM_W + 1);
  localparam int CELL_END = FIRST_CELL + MAX_CELLS;

  // Parser and statistics registers
  logic [15:0]      fv_r, fv_nxt;
  logic             has_r, has_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [16:0]      min_r, min_nxt;
  logic [15:0]      max_r, max_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // Divider registers
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // Output register
  logic        out_valid_r;
  logic        rv_r;
  logic [4:0]  cnt_out_r;
  logic [15:0] min_out_r, max_out_r, mean_out_r, spread_out_r;

  // Byte decode
  logic        is_digit, is_us, do_close, close_has, is_cell;
  logic [19:0] fv_dig;
  logic [15:0] fv_sat, close_val;

  // End of message
  logic             rep_valid;
  logic [CNT_W-1:0] cells;
  logic [31:0]      cells_raw;
  logic [16:0]      spread;

  // Divider step
  logic [CNT_W:0] shifted;
  logic           fits;

  // Decode the byte and build the digit value
  always_comb begin
    is_digit  = (in_data_byte >= CHAR_ZERO) && (in_data_byte <= CHAR_NINE);
    is_us     = (in_data_byte == CHAR_UNDERSCORE);
    fv_dig    = ({4'b0, fv_r} << 3) + ({4'b0, fv_r} << 1)
              + 20'(in_data_byte - CHAR_ZERO);
    fv_sat    = (fv_dig > VALUE_SAT) ? 16'hFFFF : fv_dig[15:0];
    close_val = is_digit ? fv_sat : fv_r;
    close_has = is_digit | has_r;
    do_close  = is_us | in_last_byte;
    is_cell   = (32'(idx_r) >= 32'(FIRST_CELL)) && (32'(idx_r) < 32'(CELL_END));
  end

  // Advance the parser and the running statistics
  always_comb begin
    fv_nxt  = fv_r;
    has_nxt = has_r;
    idx_nxt = idx_r;
    min_nxt = min_r;
    max_nxt = max_r;
    sum_nxt = sum_r;
    if (cmd.load_out) begin
      fv_nxt  = '0;
      has_nxt = 1'b0;
      idx_nxt = '0;
      min_nxt = MIN_RESET;
      max_nxt = '0;
      sum_nxt = '0;
    end else if (cmd.acc_en) begin
      if (do_close) begin
        fv_nxt  = '0;
        has_nxt = 1'b0;
        if (close_has && (32'(idx_r) < 32'(MAX_FIELDS))) begin
          if (is_cell) begin
            if ({1'b0, close_val} < min_r) begin
              min_nxt = {1'b0, close_val};
            end
            if (close_val > max_r) begin
              max_nxt = close_val;
            end
            sum_nxt = sum_r + SUM_W'(close_val);
          end
          idx_nxt = idx_r + IDX_W'(1);
        end
      end else if (is_digit) begin
        fv_nxt  = fv_sat;
        has_nxt = 1'b1;
      end
    end
  end

  // Report figures from the closed message
  always_comb begin
    rep_valid = 32'(idx_r) >= 32'(MIN_FIELDS);
    cells_raw = 32'(idx_r) - 32'(FIRST_CELL);
    cells     = (cells_raw > 32'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : CNT_W'(cells_raw);
    spread    = {1'b0, max_r} - min_r;
  end

  // Restoring division: one quotient bit per step
  always_comb begin
    shifted  = {rem_r, quo_r[SUM_W-1]};
    fits     = shifted >= {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    if (cmd.div_start) begin
      quo_nxt  = sum_r;
      rem_nxt  = '0;
      dvs_nxt  = cells;
      step_nxt = STEP_W'(SUM_W);
    end else if (cmd.div_step) begin
      quo_nxt  = {quo_r[SUM_W-2:0], fits};
      rem_nxt  = fits ? CNT_W'(shifted - {1'b0, dvs_r}) : shifted[CNT_W-1:0];
      step_nxt = step_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r   <= '0;
      has_r  <= 1'b0;
      idx_r  <= '0;
      min_r  <= MIN_RESET;
      max_r  <= '0;
      sum_r  <= '0;
      step_r <= '0;
    end else begin
      fv_r   <= fv_nxt;
      has_r  <= has_nxt;
      idx_r  <= idx_nxt;
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      sum_r  <= sum_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  // Hold the result word until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the report, zeroed when too few fields were seen
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rv_r         <= rep_valid;
      cnt_out_r    <= rep_valid ? 5'(cells) : 5'd0;
      min_out_r    <= rep_valid ? min_r[15:0] : 16'd0;
      max_out_r    <= rep_valid ? max_r : 16'd0;
      mean_out_r   <= rep_valid ? quo_r[15:0] : 16'd0;
      spread_out_r <= rep_valid ? spread[15:0] : 16'd0;
    end
  end

  assign sts.div_done = (step_r == '0);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_report_valid = rv_r;
  assign out_cell_count   = cnt_out_r;
  assign out_min_mv       = min_out_r;
  assign out_max_mv       = max_out_r;
  assign out_mean_mv      = mean_out_r;
  assign out_spread_mv    = spread_out_r;

endmodule

[rtl/cell_voltage_list_statistics.sv]
// ----------------------------------------------------------------------------
// cell_voltage_list_statistics: per-message cell voltage min/max/mean/spread
// Parses an underscore-separated decimal list and reports cell statistics.
// ----------------------------------------------------------------------------
// Message bytes are taken one per clock while in_stall is low. Digits
// build decimal fields (saturating at 65535), underscores and the last
// byte end them, every other byte is dropped. Fields from the fourth on,
// up to MAX_CELLS of them, are cell voltages. After the byte flagged last,
// the sum is divided by the cell count in a bit-serial restoring divider,
// one quotient bit per cycle, so input stalls until the quotient is ready
// and the report is loaded, and longer while the previous report word is
// still waiting to be taken. One report word follows each message; it is
// held in an output register, so the next message is accepted while it waits.
// With fewer than six fields the word carries report_valid 0 and all zeros.
module cell_voltage_list_statistics import cvls_pkg::*; #(
  parameter int MAX_FIELDS = MAX_FIELDS_DEF,
  parameter int MAX_CELLS  = MAX_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_report_valid,
  output logic [4:0]  out_cell_count,
  output logic [15:0] out_min_mv,
  output logic [15:0] out_max_mv,
  output logic [15:0] out_mean_mv,
  output logic [15:0] out_spread_mv
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  cvls_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Parser, statistics and divider
  cvls_dp #(
    .MAX_FIELDS (MAX_FIELDS),
    .MAX_CELLS  (MAX_CELLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_report_valid (out_report_valid),
    .out_cell_count   (out_cell_count),
    .out_min_mv       (out_min_mv),
    .out_max_mv       (out_max_mv),
    .out_mean_mv      (out_mean_mv),
    .out_spread_mv    (out_spread_mv)
  );

endmodule
